/* hdl/smps_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper move profile sequencer package
// Shared constants, codes and delay tables of the stepper move sequencer.
// ----------------------------------------------------------------------------
package smps_pkg;

   localparam int ACCEL_STEPS = 14;
   localparam int DECEL_STEPS = 9;
   localparam int COUNT_W     = 15;
   localparam int DELAY_W     = 5;
   localparam int DECEL_W     = 4;
   localparam int PATTERN_W   = 8;
   localparam int PHASES      = 4;

   localparam logic [DELAY_W-1:0] HOME_DELAY = 5'd18;
   localparam logic [DECEL_W-1:0] DECEL_LAST = 4'd15;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_MOVE = 2'd1;
   localparam logic [1:0] CMD_HOME = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_MOVE = 2'd1,
      MODE_HOME = 2'd2
   } mode_type;

   // The acceleration ramp falls from 20 ms by one per step and holds at 7 ms.
   function automatic logic [DELAY_W-1:0] accel_delay(input logic [COUNT_W-1:0] idx);
      logic [4:0] clamped;
      clamped = (idx > 15'd31) ? 5'd31 : idx[4:0];
      if (clamped < 5'd13) begin
         accel_delay = 5'd20 - clamped;
      end else begin
         accel_delay = 5'd7;
      end
   endfunction

   function automatic logic [DELAY_W-1:0] decel_delay(input logic [DECEL_W-1:0] idx);
      case (idx)
         4'd0:    decel_delay = 5'd8;
         4'd1:    decel_delay = 5'd9;
         4'd2:    decel_delay = 5'd10;
         4'd3:    decel_delay = 5'd11;
         4'd4:    decel_delay = 5'd12;
         4'd5:    decel_delay = 5'd14;
         4'd6:    decel_delay = 5'd16;
         4'd7:    decel_delay = 5'd18;
         default: decel_delay = 5'd20;
      endcase
   endfunction

endpackage

/* hdl/stepper_move_profile_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Stepper move profile sequencer core
// Full-step sequencer for move, homing and millisecond tick items, with a
// table-driven acceleration and deceleration delay profile.
//
//   Channel   Direction   Handshake           Payload
//   req       in          req_valid/stall     cmd, step_count, home_sensor_high
//   rsp       out         rsp_valid/stall     drive_pattern, phase_index, flags
//   csr       in          csr_write_enable    index, write data
//
// Each item is processed combinationally and its result is held in a single
// output register, so one item per clock is accepted when nothing stalls.
// The request channel stalls only while a result waits in the output register
// and the response side stalls.
// Reset clears all control and profile state; pattern registers reset to zero.
// ----------------------------------------------------------------------------
module stepper_move_profile_sequencer_core
   import smps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic signed [15:0]   req_step_count,
   input  logic                 req_home_sensor_high,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PATTERN_W-1:0] rsp_drive_pattern,
   output logic [1:0]           rsp_phase_index,
   output logic                 rsp_busy_res,
   output logic                 rsp_stepped,
   output logic                 rsp_rejected,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [PATTERN_W-1:0] csr_write_data
);

   logic [PATTERN_W-1:0] pattern_ff [PHASES];
   mode_type             mode_ff, mode_in;
   logic [1:0]           phase_ff, phase_in;
   logic                 dir_ff, dir_in;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic [COUNT_W-1:0]   pos_ff, pos_in;
   logic [DECEL_W-1:0]   decel_ff, decel_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [1:0]           home_phase_ff, home_phase_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PATTERN_W-1:0] rsp_pattern_ff;
   logic [1:0]           rsp_phase_ff;
   logic                 rsp_busy_ff, rsp_stepped_ff, rsp_rejected_ff;

   logic                 accept, busy, is_tick, wait_done, move_more;
   logic                 start_move, start_home, rejected;
   logic                 tick_move_step, tick_move_end, tick_home_step, tick_home_end;
   logic                 do_move, in_decel;
   logic [DELAY_W-1:0]   delay_dec, move_delay;
   logic [15:0]          neg_count;
   logic [COUNT_W-1:0]   magnitude;
   logic                 dir_eff;
   logic [COUNT_W-1:0]   total_eff, pos_eff;
   logic [DECEL_W-1:0]   decel_eff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign busy      = (mode_ff != MODE_IDLE);
   assign is_tick   = (req_cmd == CMD_TICK);
   assign delay_dec = (delay_ff != '0) ? delay_ff - 5'd1 : '0;
   assign wait_done = busy & (delay_dec == '0);
   assign move_more = (pos_ff < total_ff);

   assign tick_move_step = accept & is_tick & (mode_ff == MODE_MOVE) & wait_done & move_more;
   assign tick_move_end  = accept & is_tick & (mode_ff == MODE_MOVE) & wait_done & ~move_more;
   assign tick_home_step = accept & is_tick & (mode_ff == MODE_HOME) & wait_done
                           & req_home_sensor_high;
   assign tick_home_end  = accept & is_tick & (mode_ff == MODE_HOME) & wait_done
                           & ~req_home_sensor_high;
   assign start_move = accept & (req_cmd == CMD_MOVE) & ~busy & (req_step_count != '0);
   assign start_home = accept & (req_cmd == CMD_HOME) & ~busy & req_home_sensor_high;
   assign rejected   = accept & ((req_cmd == CMD_MOVE) || (req_cmd == CMD_HOME)) & busy;
   assign do_move    = start_move | tick_move_step;

   // The most negative count saturates to the largest positive magnitude.
   assign neg_count = 16'd0 - req_step_count;
   assign magnitude = req_step_count[15]
                      ? (neg_count[15] ? {COUNT_W{1'b1}} : neg_count[COUNT_W-1:0])
                      : req_step_count[COUNT_W-1:0];

   assign dir_eff   = start_move ? req_step_count[15] : dir_ff;
   assign total_eff = start_move ? magnitude : total_ff;
   assign pos_eff   = start_move ? '0 : pos_ff;
   assign decel_eff = start_move ? '0 : decel_ff;

   assign in_decel = ({1'b0, pos_eff} + 16'(DECEL_STEPS)) >= {1'b0, total_eff};

   always_comb begin
      if (pos_eff < COUNT_W'(ACCEL_STEPS)) begin
         move_delay = accel_delay(pos_eff);
      end else if (in_decel) begin
         move_delay = decel_delay(decel_eff);
      end else begin
         move_delay = accel_delay(COUNT_W'(ACCEL_STEPS - 1));
      end
   end

   // Next run mode.
   always_comb begin
      mode_in = mode_ff;
      if (start_move) begin
         mode_in = MODE_MOVE;
      end else if (start_home) begin
         mode_in = MODE_HOME;
      end else if (tick_move_end || tick_home_end) begin
         mode_in = MODE_IDLE;
      end
   end

   // Step position, phase and delay updates.
   always_comb begin
      phase_in      = phase_ff;
      dir_in        = dir_ff;
      total_in      = total_ff;
      pos_in        = pos_ff;
      decel_in      = decel_ff;
      delay_in      = delay_ff;
      home_phase_in = home_phase_ff;
      if (accept && is_tick && busy) begin
         delay_in = delay_dec;
      end
      if (do_move) begin
         dir_in   = dir_eff;
         total_in = total_eff;
         pos_in   = pos_eff + 15'd1;
         delay_in = move_delay;
         phase_in = dir_eff ? phase_ff + 2'd1 : phase_ff - 2'd1;
         decel_in = decel_eff;
         if ((pos_eff >= COUNT_W'(ACCEL_STEPS)) && in_decel && (decel_eff < DECEL_LAST)) begin
            decel_in = decel_eff + 4'd1;
         end
      end
      if (start_home) begin
         phase_in      = 2'd0;
         home_phase_in = 2'd1;
         delay_in      = HOME_DELAY;
      end else if (tick_home_step) begin
         phase_in      = home_phase_ff;
         home_phase_in = home_phase_ff + 2'd1;
         delay_in      = HOME_DELAY;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         phase_ff      <= '0;
         dir_ff        <= 1'b0;
         total_ff      <= '0;
         pos_ff        <= '0;
         decel_ff      <= '0;
         delay_ff      <= '0;
         home_phase_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < PHASES; i++) begin
            pattern_ff[i] <= '0;
         end
      end else begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         dir_ff        <= dir_in;
         total_ff      <= total_in;
         pos_ff        <= pos_in;
         decel_ff      <= decel_in;
         delay_ff      <= delay_in;
         home_phase_ff <= home_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            pattern_ff[csr_index] <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pattern_ff  <= pattern_ff[phase_in];
         rsp_phase_ff    <= phase_in;
         rsp_busy_ff     <= (mode_in != MODE_IDLE);
         rsp_stepped_ff  <= do_move | start_home | tick_home_step;
         rsp_rejected_ff <= rejected;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_pattern = rsp_pattern_ff;
   assign rsp_phase_index   = rsp_phase_ff;
   assign rsp_busy_res      = rsp_busy_ff;
   assign rsp_stepped       = rsp_stepped_ff;
   assign rsp_rejected      = rsp_rejected_ff;

   a_step_not_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_stepped && rsp_rejected))
      else $error("item both stepped and rejected");

   a_step_means_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stepped) |-> rsp_busy_res)
      else $error("step reported while idle");

   a_delay_bound: assert property (@(posedge clock) disable iff (reset)
      delay_ff <= 5'd20)
      else $error("step delay out of range");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= total_ff)
      else $error("step position past move length");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper move profile sequencer testbench
// Drives move, homing and tick items into the sequencer and predicts every
// result from a behavioral copy of the step, delay and homing logic. The
// directed tests cover idle commands, short moves across the acceleration and
// deceleration zones, homing with phase wrap, and commands rejected during a
// back-to-back move. Random traffic follows under several pattern settings,
// with random idle bursts on both channels and a quiet final stretch.
// ----------------------------------------------------------------------------
module tb;
   import smps_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [PATTERN_W-1:0] drive;
      logic [1:0]           phase;
      logic                 busy;
      logic                 stepped;
      logic                 rejected;
   } step_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_cmd = CMD_TICK;
   logic signed [15:0]   req_step_count = '0;
   logic                 req_home_sensor_high = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PATTERN_W-1:0] rsp_drive_pattern;
   logic [1:0]           rsp_phase_index;
   logic                 rsp_busy_res;
   logic                 rsp_stepped;
   logic                 rsp_rejected;
   logic                 csr_write_enable = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [PATTERN_W-1:0] csr_write_data = '0;

   // Predicted sequencer state.
   logic [PATTERN_W-1:0] pattern_reg [PHASES];
   logic [1:0]           phase = '0;
   mode_type             mode = MODE_IDLE;
   logic                 clockwise = 1'b0;
   logic [COUNT_W-1:0]   steps_total = '0;
   logic [COUNT_W-1:0]   steps_done = '0;
   logic [DECEL_W-1:0]   decel_idx = '0;
   logic [DELAY_W-1:0]   wait_left = '0;
   logic [1:0]           home_next = '0;

   step_result_type expected_steps [$];
   int              errors = 0;
   int              items_sent = 0;
   int              cycle_count = 0;
   int              stall_left = 0;
   bit              idling = 1'b1;

   stepper_move_profile_sequencer_core uut (.*);

   always #10 clock = ~clock;

   initial begin
      for (int i = 0; i < PHASES; i++) begin
         pattern_reg[i] = '0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8);
      end
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin : check_result
      step_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_steps.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
         end else begin
            want = expected_steps.pop_front();
            if (rsp_drive_pattern !== want.drive) begin
               $error("drive_pattern: expected %0h, got %0h", want.drive, rsp_drive_pattern);
               errors++;
            end
            if (rsp_phase_index !== want.phase) begin
               $error("phase_index: expected %0d, got %0d", want.phase, rsp_phase_index);
               errors++;
            end
            if (rsp_busy_res !== want.busy) begin
               $error("busy_res: expected %0b, got %0b", want.busy, rsp_busy_res);
               errors++;
            end
            if (rsp_stepped !== want.stepped) begin
               $error("stepped: expected %0b, got %0b", want.stepped, rsp_stepped);
               errors++;
            end
            if (rsp_rejected !== want.rejected) begin
               $error("rejected: expected %0b, got %0b", want.rejected, rsp_rejected);
               errors++;
            end
         end
      end
   end

   function automatic logic [DELAY_W-1:0] ramp_up_wait(input int unsigned idx);
      if (idx >= 13) begin
         return 5'd7;
      end
      return 5'(20 - idx);
   endfunction

   function automatic logic [DELAY_W-1:0] ramp_down_wait(input logic [DECEL_W-1:0] idx);
      if (idx < 5) begin
         return 5'(8 + idx);
      end else if (idx < 8) begin
         return 5'(14 + 2 * (idx - 5));
      end
      return 5'd20;
   endfunction

   task automatic take_move_step();
      int unsigned idx;
      idx = steps_done;
      phase = clockwise ? phase + 2'd1 : phase - 2'd1;
      if (idx < ACCEL_STEPS) begin
         wait_left = ramp_up_wait(idx);
      end else if (idx + DECEL_STEPS >= steps_total) begin
         wait_left = ramp_down_wait(decel_idx);
         if (decel_idx != DECEL_LAST) begin
            decel_idx++;
         end
      end else begin
         wait_left = ramp_up_wait(ACCEL_STEPS - 1);
      end
      steps_done = steps_done + 1'b1;
   endtask

   task automatic take_home_step();
      phase = home_next;
      home_next = home_next + 2'd1;
      wait_left = HOME_DELAY;
   endtask

   task automatic predict_step(input logic [1:0] cmd, input logic [15:0] count,
                               input logic sensor);
      step_result_type res;
      logic [15:0]     magnitude;
      res = '0;
      if (cmd == CMD_TICK) begin
         if (mode != MODE_IDLE) begin
            if (wait_left != 0) begin
               wait_left--;
            end
            if (wait_left == 0) begin
               if (mode == MODE_MOVE) begin
                  if (steps_done >= steps_total) begin
                     mode = MODE_IDLE;
                  end else begin
                     take_move_step();
                     res.stepped = 1'b1;
                  end
               end else if (sensor) begin
                  take_home_step();
                  res.stepped = 1'b1;
               end else begin
                  mode = MODE_IDLE;
               end
            end
         end
      end else if (cmd == CMD_MOVE || cmd == CMD_HOME) begin
         if (mode != MODE_IDLE) begin
            res.rejected = 1'b1;
         end else if (cmd == CMD_MOVE) begin
            if (count != 0) begin
               if (count[15]) begin
                  magnitude = -count;
                  if (magnitude[15]) begin
                     magnitude = 16'h7FFF;
                  end
                  clockwise = 1'b1;
               end else begin
                  magnitude = count;
                  clockwise = 1'b0;
               end
               steps_total = magnitude[COUNT_W-1:0];
               steps_done = '0;
               decel_idx = '0;
               mode = MODE_MOVE;
               take_move_step();
               res.stepped = 1'b1;
            end
         end else if (sensor) begin
            home_next = '0;
            mode = MODE_HOME;
            take_home_step();
            res.stepped = 1'b1;
         end
      end
      res.drive = pattern_reg[phase];
      res.phase = phase;
      res.busy = (mode != MODE_IDLE);
      expected_steps.push_back(res);
   endtask

   task automatic send_item(input logic [1:0] cmd, input logic [15:0] count,
                            input logic sensor);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_step_count <= count;
      req_home_sensor_high <= sensor;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_step(cmd, count, sensor);
      items_sent++;
   endtask

   task automatic send_tick(input logic sensor);
      send_item(CMD_TICK, 16'($urandom), sensor);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_steps.size() != 0);
   endtask

   task automatic program_patterns(input logic [31:0] setting);
      drain();
      for (int i = 0; i < PHASES; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= 2'(i);
         csr_write_data <= setting[8*i +: 8];
         @(posedge clock);
         pattern_reg[i] = setting[8*i +: 8];
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic finish_run();
      while (mode != MODE_IDLE) begin
         send_tick(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_move(input logic [15:0] count);
      send_item(CMD_MOVE, count, 1'($urandom_range(0, 1)));
      finish_run();
   endtask

   function automatic logic [1:0] random_command();
      case ($urandom_range(0, 2))
         0: return CMD_MOVE;
         1: return CMD_HOME;
         default: return CMD_UNUSED;
      endcase
   endfunction

   task automatic test_idle_commands();
      send_tick(1'b1);
      send_tick(1'b0);
      send_item(CMD_UNUSED, 16'h1234, 1'b1);
      send_item(CMD_MOVE, 16'h0000, 1'b1);
      send_item(CMD_HOME, 16'hFFFF, 1'b0);
   endtask

   task automatic test_short_moves();
      send_item(CMD_MOVE, 16'd1, 1'b1);
      send_item(CMD_MOVE, 16'd3, 1'b1);
      send_item(CMD_HOME, 16'd0, 1'b1);
      send_item(CMD_UNUSED, 16'd7, 1'b0);
      finish_run();
      run_move(16'hFFFF);
      run_move(16'd2);
      run_move(-16'sd5);
      run_move(16'd24);
   endtask

   task automatic test_homing();
      send_item(CMD_HOME, 16'($urandom), 1'b1);
      send_item(CMD_MOVE, 16'd5, 1'b1);
      send_item(CMD_HOME, 16'h8000, 1'b0);
      repeat (6 * HOME_DELAY) begin
         send_tick((wait_left == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      end
      while (mode != MODE_IDLE) begin
         send_tick(1'b0);
      end
   endtask

   task automatic test_long_move();
      idling = 1'b0;
      send_item(CMD_MOVE, -16'sd16, 1'b1);
      send_item(CMD_MOVE, 16'h7FFF, 1'b1);
      send_item(CMD_MOVE, 16'h8000, 1'b0);
      send_item(CMD_HOME, 16'h0000, 1'b1);
      finish_run();
      idling = 1'b1;
   endtask

   task automatic test_random_traffic(input int item_goal);
      int          goal_mark;
      int unsigned pick;
      logic [15:0] count;
      logic        sensor;
      goal_mark = items_sent + item_goal;
      while (items_sent < goal_mark) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               count = 16'($urandom_range(1, 12));
            end else if (pick < 97) begin
               count = 16'($urandom_range(13, 60));
            end else begin
               count = 16'($urandom_range(61, 200));
            end
            if ($urandom_range(0, 1)) begin
               count = -count;
            end
            send_item(CMD_MOVE, count, 1'($urandom_range(0, 1)));
         end else if (pick < 85) begin
            send_item(CMD_HOME, 16'($urandom), $urandom_range(0, 9) != 0);
         end else if ($urandom_range(0, 1)) begin
            send_item(random_command(), 16'($urandom), 1'($urandom_range(0, 1)));
         end else begin
            send_tick(1'($urandom_range(0, 1)));
         end
         while (mode != MODE_IDLE) begin
            if (mode == MODE_HOME && wait_left == 1) begin
               sensor = ($urandom_range(0, 5) != 0);
            end else begin
               sensor = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) == 0) begin
               send_item(random_command(), 16'($urandom), sensor);
            end else begin
               send_tick(sensor);
            end
         end
         if ($urandom_range(0, 7) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_idle_commands();
      program_patterns(32'h8844_2211);
      test_short_moves();
      program_patterns(32'hFFFF_FFFF);
      test_homing();
      program_patterns(32'h0FF0_3CC3);
      test_long_move();
      program_patterns(32'h0000_0000);
      test_random_traffic(50);
      program_patterns($urandom);
      test_random_traffic(60);
      program_patterns(32'hA55A_C33C);
      test_random_traffic(50);
      idling = 1'b0;
      program_patterns($urandom);
      test_random_traffic(30);
      drain();
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_steps.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/smps_pkg.sv
hdl/stepper_move_profile_sequencer_core.sv
tb/tb.sv
